>>> hdl/tcf_pkg.sv
// Package for the tilt complementary filter: types, constants, CORDIC angle table.
`default_nettype none
package tcf_pkg;
    localparam int TABLE_LEN = 24;
    localparam int TABLE_FRAC = 20;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int ACC_W = 16;
    localparam int ANG_W = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CORDIC_W = 44;
    localparam int Z_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOUNT_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_WEIGHT = 2'd2;

    localparam logic [16:0] CORR_WEIGHT_RESET = 17'd1311;

    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] g;
    } t_sample;

    typedef enum logic [2:0] {
        S_IDLE, S_ROT, S_STEP, S_GYRO, S_ACC, S_ERR, S_MUL, S_OUT
    } t_state;

    function automatic logic [Z_W-1:0] atan_q20(input logic [4:0] i);
        case (i)
            5'd0: atan_q20 = 32'd47185920;
            5'd1: atan_q20 = 32'd27855475;
            5'd2: atan_q20 = 32'd14718068;
            5'd3: atan_q20 = 32'd7471121;
            5'd4: atan_q20 = 32'd3750058;
            5'd5: atan_q20 = 32'd1876857;
            5'd6: atan_q20 = 32'd938658;
            5'd7: atan_q20 = 32'd469357;
            5'd8: atan_q20 = 32'd234682;
            5'd9: atan_q20 = 32'd117342;
            5'd10: atan_q20 = 32'd58671;
            5'd11: atan_q20 = 32'd29335;
            5'd12: atan_q20 = 32'd14668;
            5'd13: atan_q20 = 32'd7334;
            5'd14: atan_q20 = 32'd3667;
            5'd15: atan_q20 = 32'd1833;
            5'd16: atan_q20 = 32'd917;
            5'd17: atan_q20 = 32'd458;
            5'd18: atan_q20 = 32'd229;
            5'd19: atan_q20 = 32'd115;
            5'd20: atan_q20 = 32'd57;
            5'd21: atan_q20 = 32'd29;
            5'd22: atan_q20 = 32'd14;
            5'd23: atan_q20 = 32'd7;
            default: atan_q20 = 32'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

>>> hdl/tilt_complementary_filter.sv
// Top level of the tilt complementary filter.
`default_nettype none
// Tilt estimator: push one IMU sample (accel x/y, gyro z) per item, pop one
// filtered angle in 1/256 degree. The engine works on one item at a time through
// the iterative CORDIC loop and takes the next only when idle; a two-entry input queue and a
// one-entry result register decouple the two sides, and a finished result
// waits in the engine while the result register is still occupied.
// Configure only when idle.
module tilt_complementary_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_gyro_z,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [16:0]      o_angle,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import tcf_pkg::*;

    logic signed [15:0] r_gyro_offset;
    logic signed [16:0] r_mount_offset;
    logic [16:0] r_corr_weight;
    t_sample in_s, q_s;
    logic avail, take;

    assign o_cfg_ready = 1'b1;
    assign in_s = '{x: i_accel_x, y: i_accel_y, g: i_gyro_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_offset <= '0;
            r_mount_offset <= '0;
            r_corr_weight <= CORR_WEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GYRO_OFFSET: r_gyro_offset <= i_cfg_data[15:0];
                REG_MOUNT_OFFSET: r_mount_offset <= i_cfg_data[16:0];
                REG_CORR_WEIGHT: r_corr_weight <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    tcf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_sample(in_s), .i_take(take), .o_avail(avail), .o_sample(q_s)
    );

    tcf_engine #(.CORDIC_STEPS(CORDIC_STEPS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(avail), .i_sample(q_s),
        .o_take(take), .i_gyro_offset(r_gyro_offset), .i_mount_offset(r_mount_offset),
        .i_corr_weight(r_corr_weight), .i_pop(pop), .o_empty(empty), .o_angle(o_angle)
    );
endmodule
`default_nettype wire

>>> hdl/tcf_front.sv
// Front end: sample queue between the input port and the filter engine.
`default_nettype none
module tcf_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire tcf_pkg::t_sample i_sample,
    input  wire logic           i_take,
    output logic                o_avail,
    output tcf_pkg::t_sample    o_sample
);
    import tcf_pkg::*;

    // two-entry queue
    t_sample r_q0, r_q1;
    logic [1:0] r_cnt, n_cnt;
    logic do_push, do_take;

    assign o_full = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_sample = r_q0;
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_avail;

    always_comb begin
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (do_take) begin
            r_q0 <= (do_push && r_cnt == 2'd1) ? i_sample : r_q1;
        end else if (do_push && r_cnt == 2'd0) begin
            r_q0 <= i_sample;
        end
        if (do_push && ((r_cnt == 2'd1 && !do_take) || (r_cnt == 2'd2))) r_q1 <= i_sample;
    end
endmodule
`default_nettype wire

>>> hdl/tcf_engine.sv
// Back end: iterative CORDIC atan2, gyro step, correction and output register.
`default_nettype none
module tcf_engine #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_avail,
    input  wire tcf_pkg::t_sample         i_sample,
    output logic                          o_take,
    input  wire logic signed [15:0]       i_gyro_offset,
    input  wire logic signed [16:0]       i_mount_offset,
    input  wire logic [16:0]              i_corr_weight,
    input  wire logic                     i_pop,
    output logic                          o_empty,
    output logic signed [16:0]            o_angle
);
    import tcf_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int SH = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] RND = Z_W'(1) <<< (SH - 1);
    localparam logic signed [Z_W-1:0] BASE = Z_W'(180) <<< TABLE_FRAC;
    localparam int AW = 24;
    localparam logic signed [AW-1:0] HALF = AW'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [AW-1:0] FULL = AW'(360) <<< ANGLE_FRAC_BITS;
    localparam int NUM_W = 30;
    localparam int RECIP_SH = 36;
    // floor of 2^36 / 13100, a scaled reciprocal of 13100; quotient estimate is exact or one low
    localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SH) / 64'd13100);

    t_state r_state, n_state;
    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0] r_z;
    logic [4:0] r_i;
    logic r_zero;
    logic signed [15:0] r_g;
    logic r_neg;
    logic [NUM_W-1:0] r_mag;
    logic [63:0] r_prod;
    logic signed [AW-1:0] r_acc, r_step, r_pred, r_err, r_est;
    logic signed [AW+18:0] r_corr;
    logic signed [16:0] r_out;
    logic r_full;

    function automatic logic signed [AW-1:0] wrap(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] t;
        t = a;
        if (t > HALF) t = t - FULL;
        if (t < -HALF) t = t + FULL;
        return t;
    endfunction

    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [Z_W-1:0] zr;
    logic signed [16:0] neg_x, neg_y;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0] q;
    logic [NUM_W+14:0] qm;
    logic signed [AW-1:0] nxt;
    logic out_go;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        zr = (r_z + RND) >>> SH;
        neg_x = -17'(i_sample.x);
        neg_y = -17'(i_sample.y);
        num = (NUM_W'(r_g) - NUM_W'(i_gyro_offset)) <<< ANGLE_FRAC_BITS;
        q = NUM_W'(r_prod >> RECIP_SH);
        qm = (NUM_W+15)'(q) * (NUM_W+15)'(13100);
        nxt = wrap(r_pred + AW'(r_corr >>> 16));
    end

    // finished result waits here while the result register is occupied
    assign out_go = (r_state == S_OUT) && (!r_full || i_pop);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_avail) n_state = S_ROT;
            S_ROT: n_state = S_STEP;
            S_STEP: if (r_i == 5'(NSTEP - 1)) n_state = S_GYRO;
            S_GYRO: n_state = S_ACC;
            S_ACC: n_state = S_ERR;
            S_ERR: n_state = S_MUL;
            S_MUL: n_state = S_OUT;
            S_OUT: if (!r_full || i_pop) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_take = (r_state == S_IDLE) && i_avail;
    end

    assign o_empty = !r_full;
    assign o_angle = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full <= 1'b0;
            r_est <= '0;
        end else begin
            r_state <= n_state;
            if (out_go) begin
                r_full <= 1'b1;
                r_est <= (nxt > HALF) ? HALF : (nxt < -HALF) ? -HALF : nxt;
            end else if (i_pop && r_full) begin
                r_full <= 1'b0;
            end
        end
        case (r_state)
            S_IDLE: begin
                r_g <= i_sample.g;
                r_i <= '0;
                r_zero <= (i_sample.x == 0) && (i_sample.y == 0);
                if (i_sample.x < 0) begin
                    r_x <= CORDIC_W'(neg_x) <<< 24;
                    r_y <= CORDIC_W'(neg_y) <<< 24;
                    r_z <= (i_sample.y >= 0) ? BASE : -BASE;
                end else begin
                    r_x <= CORDIC_W'(i_sample.x) <<< 24;
                    r_y <= CORDIC_W'(i_sample.y) <<< 24;
                    r_z <= '0;
                end
            end
            S_ROT: begin
                r_neg <= num[NUM_W-1];
                r_mag <= (num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num)) + NUM_W'(6550);
            end
            S_STEP: begin
                if (r_y >= 0) begin
                    r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + $signed(atan_q20(r_i));
                end else begin
                    r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - $signed(atan_q20(r_i));
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'd0) r_prod <= 64'(r_mag) * 64'(RECIP);
            end
            S_GYRO: begin
                r_acc <= wrap(r_zero ? -AW'(i_mount_offset)
                                     : AW'(zr) - AW'(i_mount_offset));
                // quotient estimate may be one low
                if (qm + (NUM_W+15)'(13100) <= (NUM_W+15)'(r_mag))
                    r_step <= r_neg ? -AW'(q + 1'b1) : AW'(q + 1'b1);
                else
                    r_step <= r_neg ? -AW'(q) : AW'(q);
            end
            S_ACC: r_pred <= r_est - r_step;
            S_ERR: r_err <= wrap(r_acc - r_pred);
            S_MUL: r_corr <= (AW+19)'($signed({1'b0, i_corr_weight})) * (AW+19)'(r_err)
                             + (AW+19)'(32768);
            S_OUT: begin
                if (out_go) r_out <= 17'((nxt > HALF) ? HALF : (nxt < -HALF) ? -HALF : nxt);
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> sim/testbench.sv
// Testbench for the tilt complementary filter: directed and random IMU items checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

class angle_scoreboard;
    logic signed [15:0] gyro_bias;
    logic signed [16:0] mount_offset;
    logic [16:0]        weight;
    logic signed [16:0] estimate;
    logic signed [16:0] pending[$];
    int                 errors;

    function new();
        gyro_bias = 0;
        mount_offset = 0;
        weight = tcf_pkg::CORR_WEIGHT_RESET;
        estimate = 0;
        errors = 0;
    endfunction

    function longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function longint wrap(longint a);
        if (a > 46080) a -= 92160;
        if (a < -46080) a += 92160;
        return a;
    endfunction

    // vectoring CORDIC, angle in 1/256 degree
    function longint tilt_of(longint y, longint x);
        longint base, z, xs, ys;
        base = 0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            base = (y >= 0) ? (longint'(180) <<< 20) : -(longint'(180) <<< 20);
            x = -x;
            y = -y;
        end
        x = x * 64'sd16777216;
        y = y * 64'sd16777216;
        for (int i = 0; i < 16; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(tcf_pkg::atan_q20(i[4:0]));
            end else begin
                x -= ys; y += xs; z -= longint'(tcf_pkg::atan_q20(i[4:0]));
            end
        end
        z += base;
        return shr(z + 2048, 12);
    endfunction

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] gz);
        longint acc, num, mag, stp, pred, err, nxt;
        acc = wrap(tilt_of(ay, ax) - mount_offset);
        num = (longint'(gz) - longint'(gyro_bias)) * 256;
        mag = (num < 0) ? -num : num;
        stp = (mag + 6550) / 13100;
        if (num < 0) stp = -stp;
        pred = estimate - stp;
        err = wrap(acc - pred);
        nxt = wrap(pred + shr(longint'(weight) * err + 32768, 16));
        if (nxt > 46080) nxt = 46080;
        if (nxt < -46080) nxt = -46080;
        estimate = nxt[16:0];
        pending.push_back(estimate);
    endfunction

    function void check_angle(logic signed [16:0] got);
        logic signed [16:0] want;
        if (pending.size() == 0) begin
            $error("angle %0d popped with nothing expected", got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            $error("angle: expected %0d, got %0d", want, got);
            errors++;
        end
    endfunction
endclass

module testbench;
    import tcf_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               push = 0;
    logic               pop = 0;
    logic signed [15:0] i_accel_x = 0, i_accel_y = 0, i_gyro_z = 0;
    logic               i_cfg_valid = 0;
    logic [1:0]         i_cfg_index = 0;
    logic [31:0]        i_cfg_data = 0;
    wire                full, empty, o_cfg_ready;
    wire signed [16:0]  o_angle;

    angle_scoreboard sb = new();
    int  hold_off = 0;
    bit  stim_done = 0;

    tilt_complementary_filter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_gyro_z(i_gyro_z),
        .empty(empty), .pop(pop), .o_angle(o_angle),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random pops, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_angle(o_angle);
    end

    initial begin
        int g;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                pop <= 0;
                hold_off--;
            end else begin
                g = $urandom_range(0, 99);
                if (g < 8) begin
                    pop <= 0;
                    repeat (gap_len()) @(negedge i_clk);
                end else begin
                    pop <= ($urandom_range(0, 3) != 0);
                end
            end
        end
    end

    // push stays high after acceptance until the next task takes the inputs over
    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] gz);
        int g;
        g = gap_len();
        @(negedge i_clk);
        i_cfg_valid <= 0;
        if (g > 0) begin
            push <= 0;
            repeat (g) @(negedge i_clk);
        end
        push <= 1;
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_gyro_z <= gz;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_sample(ax, ay, gz);
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 0;
        i_cfg_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        push <= 0;
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_GYRO_OFFSET:  sb.gyro_bias = val[15:0];
            REG_MOUNT_OFFSET: sb.mount_offset = val[16:0];
            REG_CORR_WEIGHT:  sb.weight = val[16:0];
            default: ;
        endcase
    endtask

    task automatic random_phase(int n);
        logic signed [15:0] ax, ay, gz;
        int mode;
        for (int k = 0; k < n; k++) begin
            mode = $urandom_range(0, 9);
            ax = 16'($urandom);
            ay = 16'($urandom);
            gz = 16'($urandom);
            if (mode == 0) ax = 0;
            if (mode == 1) ay = 0;
            if (mode == 2) gz = 16'($urandom_range(0, 400) - 200);
            send_sample(ax, ay, gz);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: axis extremes, zero vector, negative x on the axis
        send_sample(0, 0, 0);
        send_sample(-16'sd32768, 0, 0);
        send_sample(-1, 0, 0);
        send_sample(32767, 0, 0);
        send_sample(0, 32767, 0);
        send_sample(0, -16'sd32768, 0);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(32767, 32767, 32767);
        send_sample(-16'sd32768, 1, 32767);
        send_sample(-16'sd32768, -1, -16'sd32768);
        send_sample(1, -1, 1);
        send_sample(-1, 1, -1);
        drain();

        write_reg(REG_CORR_WEIGHT, 32'd65536);
        write_reg(REG_MOUNT_OFFSET, 32'h0000B400);   // +180 deg
        write_reg(REG_GYRO_OFFSET, 32'h00007FFF);
        send_sample(-16'sd32768, 0, -16'sd32768);
        send_sample(100, -100, 32767);
        drain();
        write_reg(2'd3, 32'h12345678);
        write_reg(REG_MOUNT_OFFSET, 32'h1_4C00);     // -180 deg
        write_reg(REG_GYRO_OFFSET, 32'hFFFF8000);
        write_reg(REG_CORR_WEIGHT, 32'd0);
        send_sample(32767, 0, 32767);
        send_sample(0, 0, 32767);
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_off = 200;
        random_phase(20);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_GYRO_OFFSET, $urandom);
            write_reg(REG_MOUNT_OFFSET, $urandom_range(0, 92160) - 46080);
            write_reg(REG_CORR_WEIGHT, (p == 0) ? 32'd1311 : $urandom_range(0, 65536));
            random_phase(100);
            drain();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end
endmodule

`default_nettype wire
